// ===== rtl/tsfr_pkg.sv =====
`timescale 1ns / 1ps

package tsfr_pkg;

	// default build sizes
	localparam int DEF_MAX_TILES     = 4096;
	localparam int DEF_MAX_RAM_SLOTS = 256;

	// field widths
	localparam int BAND_W      = 4;
	localparam int ROW_W       = 6;
	localparam int COL_W       = 6;
	localparam int BANDS_CFG_W = 5;
	localparam int DIM_CFG_W   = 7;
	localparam int RAMS_CFG_W  = 9;
	localparam int CFG_DATA_W  = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int RAM_SLOT_W  = 9;
	localparam int FETCH_W     = 12;

	// tile number arithmetic
	localparam int PART_W      = 12;  // band * rows + row
	localparam int TILE_NUM_W  = 19;  // full tile number and grid product

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BANDS_USED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_BAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAM_SLOTS     = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_LOOK,
		ST_EVAL,
		ST_VREAD,
		ST_WRB,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic sweep_init;  // restart table rebuild
		logic sweep;       // write one rebuild entry
		logic accept;      // capture request beat
		logic mul1;        // band * rows + row, bounds check
		logic mul2;        // full tile number
		logic rd_t;        // read table at tile, FIFO at position
		logic res_err;     // stage range error result
		logic res_hit;     // stage hit result
		logic rd_v;        // read table at victim tile
		logic wr_t;        // install requested tile
		logic wr_v;        // move victim to backing slot
		logic load_out;    // move staged result to output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic range_err;
		logic in_ram;
	} sts_t;

endpackage

// ===== rtl/tsfr_ctrl.sv =====
`timescale 1ns / 1ps

module tsfr_ctrl import tsfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE) || cfg_we;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && !cfg_we) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_LOOK;
			end
			ST_LOOK: begin
				if (sts.range_err) begin
					cmd.res_err = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_t = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.in_ram) begin
					cmd.res_hit = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_v = 1'b1;
					state_d  = ST_VREAD;
				end
			end
			ST_VREAD: begin
				cmd.wr_t = 1'b1;
				state_d  = ST_WRB;
			end
			ST_WRB: begin
				cmd.wr_v = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		// any register write rebuilds the tables
		if (cfg_we) begin
			cmd.sweep_init = 1'b1;
			state_d        = ST_CLEAR;
		end
	end

endmodule

// ===== rtl/tsfr_dpath.sv =====
`timescale 1ns / 1ps

module tsfr_dpath import tsfr_pkg::*; #(
	parameter int MAX_TILES     = DEF_MAX_TILES,
	parameter int MAX_RAM_SLOTS = DEF_MAX_RAM_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BAND_W-1:0]     band_index,
	input  logic [ROW_W-1:0]      tile_row,
	input  logic [COL_W-1:0]      tile_col,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  hit,
	output logic [RAM_SLOT_W-1:0] ram_slot,
	output logic [FETCH_W-1:0]    fetch_slot,
	output logic [RAM_SLOT_W-1:0] victim_slot,
	output logic                  range_error
);

	localparam int TW  = $clog2(MAX_TILES);
	localparam int RW  = $clog2(MAX_RAM_SLOTS + 1);
	localparam int FW  = (MAX_RAM_SLOTS > 1) ? $clog2(MAX_RAM_SLOTS) : 1;
	localparam int GW  = $clog2(MAX_TILES + 1);
	localparam int SLW = (TW > RW) ? TW : RW;
	localparam int EW  = SLW + 1;
	localparam int SWEEP_A   = (MAX_TILES > MAX_RAM_SLOTS) ? MAX_TILES : MAX_RAM_SLOTS;
	localparam int SWEEP_LEN = (SWEEP_A > 4) ? SWEEP_A : 4;
	localparam int CW  = $clog2(SWEEP_LEN);

	// configuration registers
	logic [BANDS_CFG_W-1:0] bands_q;
	logic [DIM_CFG_W-1:0]   rows_q;
	logic [DIM_CFG_W-1:0]   tpr_q;
	logic [RAMS_CFG_W-1:0]  rams_q;

	// grid geometry
	logic [RW-1:0]         r_eff;
	logic [PART_W-1:0]     prod_br_q;
	logic [TILE_NUM_W-1:0] prod_all;
	logic [GW-1:0]         grid_q;
	logic [RW-1:0]         fifo_len_q;

	// request
	logic [BAND_W-1:0]     band_q;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic                  oob_q;
	logic [PART_W-1:0]     part_q;
	logic [TILE_NUM_W-1:0] tnum_q;

	// tables
	logic [EW-1:0] tbl_mem [MAX_TILES];
	logic [EW-1:0] tbl_rd_q;
	logic [TW-1:0] tbl_addr;
	logic [EW-1:0] tbl_wdata;
	logic [EW-1:0] sweep_entry;
	logic          tbl_we;
	logic          tbl_re;
	logic [TW-1:0] fifo_mem [MAX_RAM_SLOTS];
	logic [TW-1:0] fifo_rd_q;
	logic [FW-1:0] fifo_addr;
	logic [TW-1:0] fifo_wdata;
	logic          fifo_we;

	// swap state
	logic [CW-1:0]  cnt_q;
	logic [RW-1:0]  spare_q;
	logic [FW-1:0]  pos_q;
	logic [SLW-1:0] fetch_q;
	logic [SLW-1:0] vslot_q;

	// staged and output result
	logic                  res_hit_q;
	logic                  res_err_q;
	logic [RAM_SLOT_W-1:0] res_ram_q;
	logic [FETCH_W-1:0]    res_fetch_q;
	logic [RAM_SLOT_W-1:0] res_victim_q;
	logic                  out_hit_q;
	logic                  out_err_q;
	logic [RAM_SLOT_W-1:0] out_ram_q;
	logic [FETCH_W-1:0]    out_fetch_q;
	logic [RAM_SLOT_W-1:0] out_victim_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q <= BANDS_CFG_W'(1);
			rows_q  <= DIM_CFG_W'(64);
			tpr_q   <= DIM_CFG_W'(64);
			rams_q  <= RAMS_CFG_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BANDS_USED:    bands_q <= cfg_data[BANDS_CFG_W-1:0];
				REG_ROWS_PER_BAND: rows_q  <= cfg_data[DIM_CFG_W-1:0];
				REG_TILES_PER_ROW: tpr_q   <= cfg_data[DIM_CFG_W-1:0];
				REG_RAM_SLOTS:     rams_q  <= cfg_data[RAMS_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// resident slot count clamped to 1..MAX_RAM_SLOTS
	always_comb begin
		if (rams_q == '0) begin
			r_eff = RW'(1);
		end else if (32'(rams_q) > MAX_RAM_SLOTS) begin
			r_eff = RW'(MAX_RAM_SLOTS);
		end else begin
			r_eff = RW'(rams_q);
		end
	end

	// geometry settles within the rebuild sweep
	assign prod_all = TILE_NUM_W'(prod_br_q) * TILE_NUM_W'(tpr_q);

	always_ff @(posedge clk) begin
		prod_br_q  <= PART_W'(bands_q) * PART_W'(rows_q);
		grid_q     <= (32'(prod_all) > MAX_TILES) ? GW'(MAX_TILES) : GW'(prod_all);
		fifo_len_q <= (32'(r_eff) < 32'(grid_q)) ? r_eff : RW'(grid_q);
	end

	// tile number in two multiply steps
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			band_q <= band_index;
			row_q  <= tile_row;
			col_q  <= tile_col;
		end
		if (cmd.mul1) begin
			part_q <= PART_W'(band_q) * PART_W'(rows_q) + PART_W'(row_q);
			oob_q  <= (BANDS_CFG_W'(band_q) >= bands_q) ||
			          (DIM_CFG_W'(row_q) >= rows_q) ||
			          (DIM_CFG_W'(col_q) >= tpr_q);
		end
		if (cmd.mul2) begin
			tnum_q <= TILE_NUM_W'(part_q) * TILE_NUM_W'(tpr_q) + TILE_NUM_W'(col_q);
		end
	end

	// rebuild entry: resident slot below R, backing slot above
	always_comb begin
		if (32'(cnt_q) < 32'(r_eff)) begin
			sweep_entry = {1'b1, SLW'(cnt_q)};
		end else begin
			sweep_entry = {1'b0, SLW'(32'(cnt_q) - 32'(r_eff))};
		end
	end

	// location table port
	always_comb begin
		if (cmd.sweep) begin
			tbl_addr = cnt_q[TW-1:0];
		end else if (cmd.rd_t || cmd.wr_t) begin
			tbl_addr = tnum_q[TW-1:0];
		end else begin
			tbl_addr = fifo_rd_q;
		end
		if (cmd.sweep) begin
			tbl_wdata = sweep_entry;
		end else if (cmd.wr_t) begin
			tbl_wdata = {1'b1, SLW'(spare_q)};
		end else begin
			tbl_wdata = {1'b0, fetch_q};
		end
		tbl_we = (cmd.sweep && (32'(cnt_q) < MAX_TILES)) || cmd.wr_t || cmd.wr_v;
		tbl_re = cmd.rd_t || cmd.rd_v;
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
		if (tbl_re) tbl_rd_q <= tbl_mem[tbl_addr];
	end

	// victim FIFO port
	always_comb begin
		fifo_addr  = cmd.sweep ? cnt_q[FW-1:0] : pos_q;
		fifo_wdata = cmd.sweep ? cnt_q[TW-1:0] : tnum_q[TW-1:0];
		fifo_we    = (cmd.sweep && (32'(cnt_q) < MAX_RAM_SLOTS)) || cmd.wr_t;
	end

	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_addr] <= fifo_wdata;
		if (cmd.rd_t) fifo_rd_q <= fifo_mem[fifo_addr];
	end

	// sweep counter, spare slot and FIFO position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			spare_q <= '0;
			pos_q   <= '0;
		end else if (cmd.sweep_init) begin
			cnt_q <= '0;
		end else if (cmd.sweep) begin
			cnt_q   <= cnt_q + CW'(1);
			spare_q <= r_eff;
			pos_q   <= '0;
		end else if (cmd.wr_v) begin
			spare_q <= RW'(vslot_q);
			if (RW'(pos_q) + RW'(1) >= fifo_len_q) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + FW'(1);
			end
		end
	end

	// swap captures
	always_ff @(posedge clk) begin
		if (cmd.rd_v) fetch_q <= tbl_rd_q[SLW-1:0];
		if (cmd.wr_t) vslot_q <= tbl_rd_q[SLW-1:0];
	end

	// staged result
	always_ff @(posedge clk) begin
		if (cmd.res_err) begin
			res_hit_q    <= 1'b0;
			res_err_q    <= 1'b1;
			res_ram_q    <= '0;
			res_fetch_q  <= '0;
			res_victim_q <= '0;
		end else if (cmd.res_hit) begin
			res_hit_q    <= 1'b1;
			res_err_q    <= 1'b0;
			res_ram_q    <= RAM_SLOT_W'(tbl_rd_q[SLW-1:0]);
			res_fetch_q  <= '0;
			res_victim_q <= '0;
		end else if (cmd.wr_v) begin
			res_hit_q    <= 1'b0;
			res_err_q    <= 1'b0;
			res_ram_q    <= RAM_SLOT_W'(spare_q);
			res_fetch_q  <= FETCH_W'(fetch_q);
			res_victim_q <= RAM_SLOT_W'(vslot_q);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q    <= res_hit_q;
			out_err_q    <= res_err_q;
			out_ram_q    <= res_ram_q;
			out_fetch_q  <= res_fetch_q;
			out_victim_q <= res_victim_q;
		end
	end

	assign hit         = out_hit_q;
	assign range_error = out_err_q;
	assign ram_slot    = out_ram_q;
	assign fetch_slot  = out_fetch_q;
	assign victim_slot = out_victim_q;

	// status
	assign sts.sweep_last = (32'(cnt_q) == SWEEP_LEN - 1);
	assign sts.range_err  = oob_q || (32'(tnum_q) >= 32'(grid_q));
	assign sts.in_ram     = tbl_rd_q[EW-1];

endmodule

// ===== rtl/tile_swap_fifo_replacement.sv =====
// A request passes ST_MUL1, ST_MUL2 and ST_LOOK; a hit adds ST_EVAL, a miss
// ST_EVAL, ST_VREAD and ST_WRB, as set by the two-step tile number multiply and the
// single-port location table; ST_DONE holds the result while the output stalls.
// One request at a time. After reset and after every register write the location
// table and victim FIFO are rebuilt, one entry a cycle, over max(MAX_TILES,
// MAX_RAM_SLOTS, 4) entries (4096 at the defaults); input beats stall meanwhile.
`timescale 1ns / 1ps

module tile_swap_fifo_replacement import tsfr_pkg::*; #(
	parameter int MAX_TILES     = DEF_MAX_TILES,
	parameter int MAX_RAM_SLOTS = DEF_MAX_RAM_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BAND_W-1:0]     band_index,
	input  logic [ROW_W-1:0]      tile_row,
	input  logic [COL_W-1:0]      tile_col,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [RAM_SLOT_W-1:0] ram_slot,
	output logic [FETCH_W-1:0]    fetch_slot,
	output logic [RAM_SLOT_W-1:0] victim_slot,
	output logic                  range_error
);

	cmd_t cmd;
	sts_t sts;

	tsfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsfr_dpath #(
		.MAX_TILES     (MAX_TILES),
		.MAX_RAM_SLOTS (MAX_RAM_SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.band_index  (band_index),
		.tile_row    (tile_row),
		.tile_col    (tile_col),
		.cmd         (cmd),
		.sts         (sts),
		.hit         (hit),
		.ram_slot    (ram_slot),
		.fetch_slot  (fetch_slot),
		.victim_slot (victim_slot),
		.range_error (range_error)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import tsfr_pkg::*;

	// one request beat
	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} tile_req_t;

	// one result beat
	typedef struct packed {
		logic                  hit;
		logic [RAM_SLOT_W-1:0] ram_slot;
		logic [FETCH_W-1:0]    fetch;
		logic [RAM_SLOT_W-1:0] victim;
		logic                  range_err;
	} lookup_t;

	// location table entry: resident flag plus RAM or backing slot
	typedef struct packed {
		logic               in_ram;
		logic [FETCH_W-1:0] slot;
	} loc_t;

	// traffic idling patterns
	typedef enum {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	localparam int N_TILES = DEF_MAX_TILES;
	localparam int N_SLOTS = DEF_MAX_RAM_SLOTS;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [BAND_W-1:0]     band_index;
	logic [ROW_W-1:0]      tile_row;
	logic [COL_W-1:0]      tile_col;
	logic                  out_valid;
	logic                  out_stall;
	logic                  hit;
	logic [RAM_SLOT_W-1:0] ram_slot;
	logic [FETCH_W-1:0]    fetch_slot;
	logic [RAM_SLOT_W-1:0] victim_slot;
	logic                  range_error;

	tile_swap_fifo_replacement u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.band_index  (band_index),
		.tile_row    (tile_row),
		.tile_col    (tile_col),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.ram_slot    (ram_slot),
		.fetch_slot  (fetch_slot),
		.victim_slot (victim_slot),
		.range_error (range_error)
	);

	// shadow copy of the grid registers and the swap state
	logic [BANDS_CFG_W-1:0] cfg_bands;
	logic [DIM_CFG_W-1:0]   cfg_rows;
	logic [DIM_CFG_W-1:0]   cfg_cols;
	logic [RAMS_CFG_W-1:0]  cfg_rams;
	loc_t                   tile_map [N_TILES];
	logic [FETCH_W-1:0]     evict_order [N_SLOTS];
	int                     evict_pos;
	int                     grid_n;
	int                     order_len;
	logic [RAM_SLOT_W-1:0]  spare;

	lookup_t pending_lookups [$];

	int gap_pct;
	int stall_pct;
	int mismatches;
	int n_hit;
	int n_miss;
	int n_err;
	int n_settings;

	function automatic int cap(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	// rebuild the map from the current grid registers
	function automatic void rebuild_map();
		int prod;
		int r;
		prod = int'(cfg_bands) * int'(cfg_rows) * int'(cfg_cols);
		r = cap(int'(cfg_rams), N_SLOTS);
		if (r < 1) r = 1;
		grid_n = cap(prod, N_TILES);
		order_len = cap(r, grid_n);
		for (int i = 0; i < N_TILES; i++) begin
			if (i >= grid_n)
				tile_map[i] = '0;
			else if (i < r)
				tile_map[i] = '{in_ram: 1'b1, slot: FETCH_W'(i)};
			else
				tile_map[i] = '{in_ram: 1'b0, slot: FETCH_W'(i - r)};
		end
		for (int i = 0; i < N_SLOTS; i++)
			evict_order[i] = (i < order_len) ? FETCH_W'(i) : '0;
		evict_pos = 0;
		spare = RAM_SLOT_W'(r);
	endfunction

	// expected result for one request; updates the swap state on a miss
	function automatic lookup_t lookup_tile(input tile_req_t req);
		lookup_t res;
		loc_t    e;
		int      t;
		int      vt;
		logic [RAM_SLOT_W-1:0] vslot;
		res = '0;
		if (req.band >= cfg_bands || req.row >= cfg_rows || req.col >= cfg_cols) begin
			res.range_err = 1'b1;
			return res;
		end
		t = (int'(req.band) * int'(cfg_rows) + int'(req.row)) * int'(cfg_cols)
			+ int'(req.col);
		if (t >= grid_n || order_len == 0) begin
			res.range_err = 1'b1;
			return res;
		end
		e = tile_map[t];
		if (e.in_ram) begin
			res.hit = 1'b1;
			res.ram_slot = e.slot[RAM_SLOT_W-1:0];
			return res;
		end
		// miss: load into spare, evict the tile at the FIFO head
		if (evict_pos >= order_len) evict_pos = 0;
		vt = int'(evict_order[evict_pos]);
		vslot = tile_map[vt].slot[RAM_SLOT_W-1:0];
		res.ram_slot = spare;
		res.fetch = e.slot;
		res.victim = vslot;
		tile_map[t] = '{in_ram: 1'b1, slot: FETCH_W'(spare)};
		tile_map[vt] = '{in_ram: 1'b0, slot: e.slot};
		spare = vslot;
		evict_order[evict_pos] = FETCH_W'(t);
		evict_pos = (evict_pos + 1) % order_len;
		return res;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		lookup_t want;
		lookup_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{hit, ram_slot, fetch_slot, victim_slot, range_error};
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: hit=%0d ram=%0d fetch=%0d victim=%0d err=%0d",
						got.hit, got.ram_slot, got.fetch, got.victim, got.range_err);
			end else begin
				want = pending_lookups.pop_front();
				if (want.range_err) n_err++;
				else if (want.hit) n_hit++;
				else n_miss++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch: exp hit=%0d ram=%0d fetch=%0d victim=%0d err=%0d",
							want.hit, want.ram_slot, want.fetch, want.victim, want.range_err);
						$display("                 got hit=%0d ram=%0d fetch=%0d victim=%0d err=%0d",
							got.hit, got.ram_slot, got.fetch, got.victim, got.range_err);
					end
				end
			end
		end
	end

	// send one request beat; valid stays high unless the next beat idles first
	task automatic send_tile(input tile_req_t req);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		band_index <= req.band;
		tile_row <= req.row;
		tile_col <= req.col;
		do @(posedge clk); while (in_stall);
		pending_lookups = {pending_lookups, lookup_tile(req)};
	endtask

	task automatic send_coords(input int b, input int r, input int c);
		send_tile('{band: BAND_W'(b), row: ROW_W'(r), col: COL_W'(c)});
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_lookups.size() != 0);
	endtask

	// register write; the block rebuilds its tables afterwards
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BANDS_USED:    cfg_bands = BANDS_CFG_W'(val);
			REG_ROWS_PER_BAND: cfg_rows = DIM_CFG_W'(val);
			REG_TILES_PER_ROW: cfg_cols = DIM_CFG_W'(val);
			REG_RAM_SLOTS:     cfg_rams = RAMS_CFG_W'(val);
			default: ;
		endcase
		rebuild_map();
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic apply_grid(input int bands, input int rows, input int cols, input int rams);
		wait_results();
		write_reg(REG_BANDS_USED, bands);
		write_reg(REG_ROWS_PER_BAND, rows);
		write_reg(REG_TILES_PER_ROW, cols);
		write_reg(REG_RAM_SLOTS, rams);
		n_settings++;
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin gap_pct = 64; stall_pct = 0;  end
			IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 64; end
			default:       begin gap_pct = 28; stall_pct = 28; end
		endcase
	endtask

	// reset grid: first tiles resident, the rest in backing store
	task automatic test_default_grid();
		set_idle(IDLE_NONE);
		send_coords(0, 0, 0);
		send_coords(0, 3, 63);
		send_coords(0, 4, 0);
		send_coords(0, 63, 63);
		send_coords(0, 0, 0);
		send_coords(1, 0, 0);
		send_coords(15, 63, 63);
		send_coords(0, 63, 63);
		send_coords(0, 21, 42);
	endtask

	// any zero dimension: every request is out of range
	task automatic test_empty_grid();
		apply_grid(0, 0, 0, 0);
		send_coords(0, 0, 0);
		send_coords(15, 63, 63);
	endtask

	// dimensions past the built grid, tile count saturates
	task automatic test_oversized_grid();
		apply_grid(31, 127, 127, 511);
		send_coords(15, 63, 63);
		send_coords(0, 0, 0);
		send_coords(0, 32, 32);
		send_coords(0, 32, 31);
		send_coords(0, 32, 31);
	endtask

	// zero RAM slots act as one: every miss swaps out the single resident tile
	task automatic test_single_slot();
		apply_grid(2, 3, 5, 0);
		send_coords(0, 0, 0);
		send_coords(1, 2, 4);
		send_coords(0, 0, 0);
		send_coords(1, 2, 4);
		send_coords(0, 3, 0);
		send_coords(2, 0, 0);
		send_coords(0, 0, 5);
	endtask

	// mostly in-grid requests with a recently used set for hits, some noise
	task automatic run_traffic(input int items, input idle_mode_t mode);
		tile_req_t req;
		tile_req_t recent [$];
		int        pick;
		set_idle(mode);
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			if (pick < 10 || cfg_bands == 0 || cfg_rows == 0 || cfg_cols == 0) begin
				req = 16'($urandom);
			end else if (pick < 45 && recent.size() != 0) begin
				req = recent[$urandom_range(recent.size() - 1)];
			end else begin
				req.band = BAND_W'($urandom_range(cap(int'(cfg_bands), 16) - 1));
				req.row = ROW_W'($urandom_range(cap(int'(cfg_rows), 64) - 1));
				req.col = COL_W'($urandom_range(cap(int'(cfg_cols), 64) - 1));
			end
			recent = {recent, req};
			if (recent.size() > 8) recent.pop_front();
			send_tile(req);
			if (i == items / 2) wait_results();
		end
	endtask

	task automatic test_random_traffic();
		apply_grid(1, 64, 64, 256);
		run_traffic(165, IDLE_NONE);
		apply_grid(2, 3, 5, 4);
		run_traffic(165, IDLE_SENDER);
		apply_grid(16, 4, 4, 16);
		run_traffic(165, IDLE_RECEIVER);
		apply_grid(3, 7, 9, 1);
		run_traffic(165, IDLE_BOTH);
		apply_grid(16, 16, 16, 256);
		run_traffic(165, IDLE_NONE);
		apply_grid($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, 8),
			$urandom_range(1, 64));
		run_traffic(165, IDLE_SENDER);
		apply_grid($urandom_range(31), $urandom_range(127), $urandom_range(127),
			$urandom_range(511));
		run_traffic(165, IDLE_RECEIVER);
		apply_grid(4, 2, 2, 8);
		run_traffic(165, IDLE_BOTH);
	endtask

	// run limit
	initial begin
		#15_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BANDS_USED;
		cfg_data <= '0;
		in_valid <= 1'b0;
		band_index <= '0;
		tile_row <= '0;
		tile_col <= '0;
		out_stall <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		n_hit = 0;
		n_miss = 0;
		n_err = 0;
		n_settings = 1;
		cfg_bands = 1;
		cfg_rows = 64;
		cfg_cols = 64;
		cfg_rams = 256;
		rebuild_map();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_default_grid();
		test_empty_grid();
		test_oversized_grid();
		test_single_slot();
		test_random_traffic();

		wait_results();
		repeat (16) @(posedge clk);
		if (pending_lookups.size() != 0) mismatches += pending_lookups.size();

		$display("checked %0d lookups: %0d hits, %0d swaps, %0d out of range, over %0d grid setups",
			n_hit + n_miss + n_err, n_hit, n_miss, n_err, n_settings);
		$display("traffic ran with no idling, sender gaps, receiver stalls and both mixed");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
